[hdl/rcfp_pkg.sv]
// ----------------------------------------------------------------------------
// rcfp_pkg
// Shared types, constants and the byte-wide crc-16 step for the rc frame
// parser.
// ----------------------------------------------------------------------------
package rcfp_pkg;

    localparam logic [15:0] CRC_POLY   = 16'h8005;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  HDR_MASK   = 8'h3F;
    localparam logic [7:0]  HDR_MATCH  = 8'h2A;
    localparam logic [7:0]  LOST_MASK  = 8'hC0;
    localparam logic [7:0]  LOST_MATCH = 8'h40;

    // byte positions inside the 12-byte frame
    localparam int          STORE_LEN = 11;
    localparam logic [3:0]  POS_FIRST = 4'd1;
    localparam logic [3:0]  POS_CRC   = 4'd3;
    localparam logic [3:0]  POS_LAST  = 4'd11;

    // lqi report modes
    localparam logic [1:0]  LQI_OFF  = 2'd0;
    localparam logic [1:0]  LQI_BYTE = 2'd1;
    localparam logic [1:0]  LQI_ZERO = 2'd2;

    localparam int          TDATA_W = 72;
    localparam int          TUSER_W = 1;

    // stored bytes 0 to 10 and the crc over bytes 3 to 10
    typedef struct packed {
        logic [STORE_LEN-1:0][7:0] bytes;
        logic [15:0]               crc;
    } t_frame;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[15] ^ data[7-i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

[hdl/rcfp_collect.sv]
// ----------------------------------------------------------------------------
// rcfp_collect
// Header hunt, byte position tracking, frame byte store and running crc.
// ----------------------------------------------------------------------------
module rcfp_collect (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_byte_fire,
    input  logic [7:0]      i_byte,
    output logic            o_closing,
    output rcfp_pkg::t_frame o_frame
);
    import rcfp_pkg::*;

    logic                      r_in_frame;
    logic [3:0]                r_pos;
    logic [15:0]               r_crc;
    logic [STORE_LEN-1:0][7:0] r_bytes;

    logic                      n_in_frame;
    logic [3:0]                n_pos;
    logic [15:0]               n_crc;
    logic                      hdr_hit;

    assign hdr_hit   = (i_byte & HDR_MASK) == HDR_MATCH;
    assign o_closing = r_in_frame && (r_pos >= POS_LAST);

    always_comb begin
        n_in_frame = r_in_frame;
        n_pos      = r_pos;
        n_crc      = r_crc;
        if (i_byte_fire) begin
            if (!r_in_frame) begin
                if (hdr_hit) begin
                    n_in_frame = 1'b1;
                    n_pos      = POS_FIRST;
                    n_crc      = CRC_INIT;
                end
            end else if (o_closing) begin
                n_in_frame = 1'b0;
                n_pos      = '0;
                n_crc      = CRC_INIT;
            end else begin
                if (r_pos >= POS_CRC) begin
                    n_crc = crc16_byte(r_crc, i_byte);
                end
                n_pos = r_pos + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_crc      <= CRC_INIT;
        end else begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
        end
    end

    // byte store, header lands at entry 0, the closing byte is not kept
    always_ff @(posedge i_clk) begin
        if (i_byte_fire) begin
            if (!r_in_frame) begin
                if (hdr_hit) begin
                    r_bytes[0] <= i_byte;
                end
            end else if (!o_closing) begin
                r_bytes[r_pos] <= i_byte;
            end
        end
    end

    assign o_frame.bytes = r_bytes;
    assign o_frame.crc   = r_crc;

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (r_pos == '0))
        else $error("byte position not cleared while hunting");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_pos >= POS_FIRST && r_pos <= POS_LAST))
        else $error("byte position out of frame range");

    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_byte_fire && o_closing) |=> (r_crc == CRC_INIT && !r_in_frame))
        else $error("crc not restarted after frame close");

endmodule

[hdl/rcfp_format.sv]
// ----------------------------------------------------------------------------
// rcfp_format
// Crc check, channel and aux unpacking, lqi gating and the result register.
// ----------------------------------------------------------------------------
module rcfp_format (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_close_fire,
    input  rcfp_pkg::t_frame              i_frame,
    input  logic [1:0]                    i_lqi_mode,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [rcfp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic [rcfp_pkg::TUSER_W-1:0]  o_m_tuser
);
    import rcfp_pkg::*;

    logic                 r_valid;
    logic [TDATA_W-1:0]   r_tdata;
    logic [TUSER_W-1:0]   r_tuser;

    logic [TDATA_W-1:0]   n_tdata;
    logic                 crc_ok;
    logic                 lost;
    logic [10:0]          chan_a;
    logic [10:0]          chan_b;
    logic [10:0]          chan_c;
    logic [10:0]          chan_d;
    logic [11:0]          aux;
    logic                 lqi_valid;
    logic [7:0]           lqi_value;
    logic [7:0]           b0, b3, b4, b5, b6, b7, b8, b9, b10;

    assign b0  = i_frame.bytes[0];
    assign b3  = i_frame.bytes[3];
    assign b4  = i_frame.bytes[4];
    assign b5  = i_frame.bytes[5];
    assign b6  = i_frame.bytes[6];
    assign b7  = i_frame.bytes[7];
    assign b8  = i_frame.bytes[8];
    assign b9  = i_frame.bytes[9];
    assign b10 = i_frame.bytes[10];

    // received crc is byte 1 high, byte 2 low
    assign crc_ok = i_frame.crc == {i_frame.bytes[1], i_frame.bytes[2]};
    assign lost   = (b0 & LOST_MASK) == LOST_MATCH;

    always_comb begin
        chan_a    = '0;
        chan_b    = '0;
        chan_c    = '0;
        chan_d    = '0;
        aux       = '0;
        lqi_valid = 1'b0;
        lqi_value = '0;
        if (crc_ok) begin
            if (!lost) begin
                chan_a = {b4[2:0], b3};
                chan_b = {b5[6:0], b4[7:4]};
                chan_c = {b7[2:0], b6};
                chan_d = {b8[6:0], b7[7:4]};
                aux    = {b9, b8[7], b7[3], b5[7], b4[3]};
            end
            case (i_lqi_mode)
                LQI_BYTE: begin
                    lqi_valid = 1'b1;
                    lqi_value = b10;
                end
                LQI_ZERO: begin
                    lqi_valid = 1'b1;
                end
                default: begin
                    lqi_valid = 1'b0;
                end
            endcase
        end
        n_tdata = {6'd0, lqi_value, lqi_valid, aux, chan_d, chan_c, chan_b,
                   chan_a, crc_ok & lost};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_close_fire) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_close_fire) begin
            r_tdata <= n_tdata;
            r_tuser <= TUSER_W'(!crc_ok);
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_close_fire |-> (!r_valid || i_m_tready))
        else $error("result register overwritten before transaction");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_tuser[0]) |-> (r_tdata == '0))
        else $error("payload not zero on crc error");

endmodule

[hdl/rc_frame_crc16_parser.sv]
// ----------------------------------------------------------------------------
// rc_frame_crc16_parser
// Byte-serial receiver for a 12-byte rc control frame with crc-16 check.
// ----------------------------------------------------------------------------
//  channel   dir  handshake               payload
//  s         in   i_s_tvalid/o_s_tready   rx_byte
//  m         out  o_m_tvalid/i_m_tready   status in tuser, frame fields in tdata
//  cfg       in   i_cfg_valid/o_cfg_ready lqi_mode
//
//  one byte per cycle; the crc step is a single registered byte-wide update
//  the closing byte loads the result register at its accepting edge, the
//  result is valid in the next cycle
//  only the closing byte can stall, and only while a result waits untaken
//  synchronous active-low reset puts the block in header hunt, crc 0xFFFF
//  lqi_mode resets to 0 and is always writable
// ----------------------------------------------------------------------------
module rc_frame_crc16_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // rx_byte[7:0]
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // frame_lost[0], chan_a[11:1], chan_b[22:12], chan_c[33:23],
    // chan_d[44:34], aux_switches[56:45], lqi_valid[57], lqi_value[65:58]
    output logic [rcfp_pkg::TDATA_W-1:0]  o_m_tdata,
    output logic [rcfp_pkg::TUSER_W-1:0]  o_m_tuser,   // status[0]
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_data   // lqi_mode[1:0]
);
    import rcfp_pkg::*;

    logic       lqi_on;
    logic [1:0] r_lqi_mode_q;
    logic       byte_fire;
    logic       closing;
    logic       close_fire;
    t_frame     frame;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lqi_mode_q <= LQI_OFF;
        end else if (i_cfg_valid) begin
            r_lqi_mode_q <= i_cfg_data;
        end
    end

    // marks a non-default lqi mode, used by the checks below
    assign lqi_on = r_lqi_mode_q != LQI_OFF;

    assign o_s_tready = !(closing && o_m_tvalid && !i_m_tready);
    assign byte_fire  = i_s_tvalid && o_s_tready;
    assign close_fire = byte_fire && closing;

    rcfp_collect u_collect (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_fire (byte_fire),
        .i_byte      (i_s_tdata),
        .o_closing   (closing),
        .o_frame     (frame)
    );

    rcfp_format u_format (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_close_fire (close_fire),
        .i_frame      (frame),
        .i_lqi_mode   (r_lqi_mode_q),
        .i_m_tready   (i_m_tready),
        .o_m_tvalid   (o_m_tvalid),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

    a_close_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        close_fire |=> o_m_tvalid)
        else $error("frame close did not produce a result");

    a_lqi_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (close_fire && !lqi_on) |=> !o_m_tdata[57])
        else $error("lqi reported with lqi mode off");

endmodule
